// ----- hw/rtl/kpd_pkg.sv -----
`timescale 1ns / 1ps

package kpd_pkg;

  // matrix geometry and counter defaults
  localparam int ROWS_DEF        = 4;
  localparam int COLS_DEF        = 4;
  localparam int COUNT_WIDTH_DEF = 8;

  // fixed field widths of the channels
  localparam int ROW_W   = 2;
  localparam int COL_W   = 4;
  localparam int MAP_W   = 16;
  localparam int LIMIT_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

endpackage

// ----- hw/rtl/kpd_ifs.sv -----
`timescale 1ns / 1ps

interface kpd_in_if;
  logic                      valid;
  logic                      ready;
  logic [kpd_pkg::ROW_W-1:0] row_index;
  logic [kpd_pkg::COL_W-1:0] column_levels;

  modport source (output valid, output row_index, output column_levels, input ready);
  modport sink   (input valid, input row_index, input column_levels, output ready);
endinterface

interface kpd_out_if;
  logic                      valid;
  logic                      ready;
  logic [kpd_pkg::MAP_W-1:0] pressed_map;
  logic [kpd_pkg::MAP_W-1:0] clicked_map;
  logic [kpd_pkg::MAP_W-1:0] released_map;

  modport source (output valid, output pressed_map, output clicked_map,
                  output released_map, input ready);
  modport sink   (input valid, input pressed_map, input clicked_map,
                  input released_map, output ready);
endinterface

interface kpd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kpd_pkg::LIMIT_W-1:0] debounce_limit;

  modport source (output valid, output debounce_limit, input ready);
  modport sink   (input valid, input debounce_limit, output ready);
endinterface

// ----- hw/rtl/kpd_limit_reg.sv -----
`timescale 1ns / 1ps

module kpd_limit_reg #(
  parameter int COUNT_WIDTH = kpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  kpd_cfg_if.sink                cfg_chan,
  output logic [COUNT_WIDTH-1:0] eff_limit
);

  localparam int CMP_W     = 17;
  localparam int COUNT_MAX = (1 << COUNT_WIDTH) - 1;

  logic [kpd_pkg::LIMIT_W-1:0] limit_r;
  logic [CMP_W-1:0]            limit_ext;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= kpd_pkg::LIMIT_RESET;
    end else if (cfg_chan.valid) begin
      limit_r <= cfg_chan.debounce_limit;
    end
  end

  // a limit beyond the counter range saturates at the counter maximum
  assign limit_ext = CMP_W'(limit_r);

  always_comb begin
    if (limit_ext > CMP_W'(COUNT_MAX)) begin
      eff_limit = COUNT_WIDTH'(COUNT_MAX);
    end else begin
      eff_limit = COUNT_WIDTH'(limit_r);
    end
  end

endmodule

// ----- hw/rtl/kpd_row_update.sv -----
`timescale 1ns / 1ps

module kpd_row_update #(
  parameter int ROWS        = kpd_pkg::ROWS_DEF,
  parameter int COLS        = kpd_pkg::COLS_DEF,
  parameter int COUNT_WIDTH = kpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic [kpd_pkg::ROW_W-1:0]                 row,
  input  logic [kpd_pkg::COL_W-1:0]                 cols,
  input  logic [COUNT_WIDTH-1:0]                    limit,
  input  logic [ROWS*COLS-1:0][COUNT_WIDTH-1:0]     cnt,
  input  logic [ROWS*COLS-1:0]                      pressed,
  input  logic [ROWS*COLS-1:0]                      prev,
  output logic [ROWS*COLS-1:0][COUNT_WIDTH-1:0]     cnt_nxt,
  output logic [ROWS*COLS-1:0]                      pressed_nxt,
  output logic [ROWS*COLS-1:0]                      prev_nxt
);

  localparam int KEYS = ROWS * COLS;

  for (genvar k = 0; k < KEYS; k++) begin : g_key
    localparam int KROW = k / COLS;
    localparam int KCOL = k % COLS;

    logic                   en;
    logic                   level;
    logic [COUNT_WIDTH-1:0] c_nxt;

    assign en = (int'(row) == KROW);

    if (KCOL < kpd_pkg::COL_W) begin : g_lvl
      assign level = cols[KCOL];
    end else begin : g_nolvl
      assign level = 1'b0;
    end

    // saturating count, up to the limit on contact, down to zero otherwise
    always_comb begin
      c_nxt = cnt[k];
      if (level) begin
        if (cnt[k] < limit) begin
          c_nxt = cnt[k] + COUNT_WIDTH'(1);
        end
      end else if (cnt[k] != '0) begin
        c_nxt = cnt[k] - COUNT_WIDTH'(1);
      end
    end

    always_comb begin
      cnt_nxt[k]     = cnt[k];
      pressed_nxt[k] = pressed[k];
      prev_nxt[k]    = prev[k];
      if (en) begin
        cnt_nxt[k]  = c_nxt;
        prev_nxt[k] = pressed[k];
        // hysteresis: state only moves at the two ends of the count
        if (c_nxt == '0) begin
          pressed_nxt[k] = 1'b0;
        end else if (c_nxt == limit) begin
          pressed_nxt[k] = 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/matrix_keypad_debouncer_top.sv -----
`timescale 1ns / 1ps

// Key matrix debouncer.
// in_chan carries one scanned row per item: row_index and the four sampled
// column levels (1 = contact). Each item updates the saturating counters of
// that row's keys and yields one item on out_chan with the full pressed,
// clicked (off to on) and released (on to off) key maps, bit row*COLS+col.
// cfg_chan writes the debounce limit; it is always ready and takes effect
// for items processed after the write. Write it only while the block is idle.
// An accepted item passes two registers (input stage, then result stage)
// before out_chan presents it. Throughput is one item per cycle while
// out_chan does not stall, set by the single combinational key update between them.
// Reset (rst_n low, synchronous) clears all counters and key states, sets
// the limit to 5 and empties both stages.
// When out_chan stalls, the result holds steady; in_chan takes one more item
// into an empty input stage and then drops ready until the result is taken.
module matrix_keypad_debouncer_top #(
  parameter int ROWS        = kpd_pkg::ROWS_DEF,
  parameter int COLS        = kpd_pkg::COLS_DEF,
  parameter int COUNT_WIDTH = kpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  kpd_in_if.sink    in_chan,
  kpd_out_if.source out_chan,
  kpd_cfg_if.sink   cfg_chan
);

  localparam int KEYS = ROWS * COLS;

  logic                              s1_valid_r;
  logic [kpd_pkg::ROW_W-1:0]         s1_row_r;
  logic [kpd_pkg::COL_W-1:0]         s1_cols_r;
  logic [KEYS-1:0][COUNT_WIDTH-1:0]  cnt_r;
  logic [KEYS-1:0][COUNT_WIDTH-1:0]  cnt_nxt;
  logic [KEYS-1:0]                   pressed_r;
  logic [KEYS-1:0]                   pressed_nxt;
  logic [KEYS-1:0]                   prev_r;
  logic [KEYS-1:0]                   prev_nxt;
  logic                              out_valid_r;
  logic [kpd_pkg::MAP_W-1:0]         pressed_map_r;
  logic [kpd_pkg::MAP_W-1:0]         clicked_map_r;
  logic [kpd_pkg::MAP_W-1:0]         released_map_r;
  logic [COUNT_WIDTH-1:0]            eff_limit;
  logic                              advance;
  logic                              in_take;

  kpd_limit_reg #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_limit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_chan  (cfg_chan),
    .eff_limit (eff_limit)
  );

  kpd_row_update #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_update (
    .row         (s1_row_r),
    .cols        (s1_cols_r),
    .limit       (eff_limit),
    .cnt         (cnt_r),
    .pressed     (pressed_r),
    .prev        (prev_r),
    .cnt_nxt     (cnt_nxt),
    .pressed_nxt (pressed_nxt),
    .prev_nxt    (prev_nxt)
  );

  // the input stage moves on whenever the result register is free
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pressed_r   <= '0;
      prev_r      <= '0;
      for (int k = 0; k < KEYS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
        pressed_r   <= pressed_nxt;
        prev_r      <= prev_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_row_r  <= in_chan.row_index;
      s1_cols_r <= in_chan.column_levels;
    end
    if (advance) begin
      pressed_map_r  <= kpd_pkg::MAP_W'(pressed_nxt);
      clicked_map_r  <= kpd_pkg::MAP_W'(~prev_nxt & pressed_nxt);
      released_map_r <= kpd_pkg::MAP_W'(prev_nxt & ~pressed_nxt);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pressed_map  = pressed_map_r;
  assign out_chan.clicked_map  = clicked_map_r;
  assign out_chan.released_map = released_map_r;

endmodule

// ----- hw/rtl/kpd_checker.sv -----
`timescale 1ns / 1ps

module kpd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [kpd_pkg::MAP_W-1:0] pressed,
  input logic [kpd_pkg::MAP_W-1:0] clicked,
  input logic [kpd_pkg::MAP_W-1:0] released
);

  // a key cannot click and release in the same result
  a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((clicked & released) == '0))
    else $error("click and release set for the same key");

  // a click means the key is pressed now, a release means it is not
  a_edges_match_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((clicked & ~pressed) == '0) && ((released & pressed) == '0)))
    else $error("edge map disagrees with pressed map");

  // input backpressure only comes from a stalled result
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input not ready without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(pressed) && $stable(clicked)
                                   && $stable(released)))
    else $error("stalled result changed");

endmodule

bind matrix_keypad_debouncer_top kpd_checker u_kpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .pressed   (out_chan.pressed_map),
  .clicked   (out_chan.clicked_map),
  .released  (out_chan.released_map)
);
